// ===== rtl/grid_laplacian_smoother_top_assert.svh =====
// Assertion macros for the grid smoother.
// No dependencies; taken in by grid_laplacian_smoother_top.
`ifndef GRID_LAPLACIAN_SMOOTHER_TOP_ASSERT_SVH
`define GRID_LAPLACIAN_SMOOTHER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define GLS_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);
`define GLS_ASSERT_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);
`else
`define GLS_ASSERT(lbl, ck, rs, prop, msg)
`define GLS_ASSERT_ALWAYS(lbl, ck, prop, msg)
`endif
`endif

// ===== rtl/gls_pkg.sv =====
// Shared codes and types for the grid smoother.
// No dependencies.
package gls_pkg;

  localparam logic [1:0] FUNC_WRITE  = 2'd0;
  localparam logic [1:0] FUNC_RUN    = 2'd1;
  localparam logic [1:0] FUNC_READ   = 2'd2;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  localparam logic [1:0] REG_COLUMNS = 2'd0;
  localparam logic [1:0] REG_ROWS    = 2'd1;
  localparam logic [1:0] REG_TOL     = 2'd2;
  localparam logic [1:0] REG_LIMIT   = 2'd3;

  localparam logic [6:0] COLUMNS_RESET = 7'd64;
  localparam logic [6:0] ROWS_RESET    = 7'd64;
  localparam logic [9:0] LIMIT_RESET   = 10'd1000;

  typedef enum logic [12:0] {
    S_IDLE     = 13'b0000000000001,
    S_WRITE    = 13'b0000000000010,
    S_READ     = 13'b0000000000100,
    S_READ_OUT = 13'b0000000001000,
    S_TOL      = 13'b0000000010000,
    S_SWEEP    = 13'b0000000100000,
    S_NODE     = 13'b0000001000000,
    S_UPD      = 13'b0000010000000,
    S_CHK      = 13'b0000100000000,
    S_SQX      = 13'b0001000000000,
    S_SQY      = 13'b0010000000000,
    S_CMP      = 13'b0100000000000,
    S_NEXT     = 13'b1000000000000
  } state_t;

endpackage

// ===== rtl/gls_ram.sv =====
// Generic single-port RAM, registered read.
// No dependencies.
module gls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/grid_laplacian_smoother_top.sv =====
// Grid Laplacian smoother: node store, Gauss-Seidel sweep sequencer.
// Depends on gls_pkg, gls_ram and grid_laplacian_smoother_top_assert.svh.
//
// Usage: one command word is taken when start is high and busy is low.
// func selects write node, run smoothing or read node; row_index and
// column_index address the node, coord_x/coord_y carry write data.
// Every command returns exactly one result word, shown for one cycle with
// done high: out_x/out_y (read data, zero for other commands), sweeps_done
// and converged (status of the last run).
// A run sweeps the grid node by node: per interior node, five reads through
// the single store port, one write-back, then a tolerance check on one shared
// 16x16 multiplier. busy stays high until done.
// The config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
// ready; write it only while the block is idle.
// Reset (synchronous rst) restores the register defaults and clears the
// run status; the node store keeps no reset and must be loaded first.
// The receiver cannot stall: done is a strobe, not a handshake.
`include "grid_laplacian_smoother_top_assert.svh"
module grid_laplacian_smoother_top
  import gls_pkg::*;
#(
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_ROWS    = 64,
  parameter int COORD_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         func,
  input  logic [5:0]         row_index,
  input  logic [5:0]         column_index,
  input  logic signed [31:0] coord_x,
  input  logic signed [31:0] coord_y,
  output logic               done,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic [9:0]         sweeps_done,
  output logic               converged,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int RB    = $clog2(MAX_ROWS);
  localparam int CB    = $clog2(MAX_COLUMNS);
  localparam int AW    = RB + CB;
  localparam int DEPTH = MAX_ROWS << CB;
  localparam int CW    = COORD_WIDTH;
  localparam int SW    = CW + 2;   // sum of four neighbors
  localparam int DW    = CW + 1;   // difference / movement

  // config registers
  logic [6:0]  grid_columns, grid_rows;
  logic [15:0] move_tolerance;
  logic [9:0]  iteration_limit;

  // run status
  logic [9:0] last_sweeps;
  logic       last_converged;

  state_t state;

  // latched command
  logic          cmd_inside;
  logic [AW-1:0] cmd_addr;
  logic [CW-1:0] cmd_x, cmd_y;

  // sweep state
  logic [RB-1:0]        row, row_last;
  logic [CB-1:0]        col, col_last;
  logic [2:0]           ph;
  logic [9:0]           sweeps;
  logic                 moved;
  logic signed [SW-1:0] sum_x, sum_y;
  logic [CW-1:0]        old_x, old_y;
  logic [DW-1:0]        dx, dy;
  logic [31:0]          tol2, sqx, sqy;

  // store port
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [CW-1:0] ram_wx, ram_wy, ram_rx, ram_ry;

  // shared multiplier
  logic [15:0] mul_op;
  logic [31:0] prod;

  logic [8:0]            cols_eff, rows_eff;
  logic [CW+31:0]        wx_ext, wy_ext, rx_ext, ry_ext;
  logic [CW-1:0]         nx, ny;
  logic signed [DW-1:0]  diff_x, diff_y;
  logic [32:0]           sq_sum;
  logic                  accept;

  assign accept    = start && !busy;
  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  assign sweeps_done = last_sweeps;
  assign converged   = last_converged;

  assign cols_eff = (9'(grid_columns) > 9'(MAX_COLUMNS)) ? 9'(MAX_COLUMNS) : 9'(grid_columns);
  assign rows_eff = (9'(grid_rows) > 9'(MAX_ROWS)) ? 9'(MAX_ROWS) : 9'(grid_rows);

  // coordinates wrap to CW bits on write, low 32 bits on read
  assign wx_ext = {{CW{coord_x[31]}}, coord_x};
  assign wy_ext = {{CW{coord_y[31]}}, coord_y};
  assign rx_ext = {{32{ram_rx[CW-1]}}, ram_rx};
  assign ry_ext = {{32{ram_ry[CW-1]}}, ram_ry};

  // floor of the neighbor average; always fits CW bits
  assign nx     = sum_x[CW+1:2];
  assign ny     = sum_y[CW+1:2];
  assign diff_x = $signed({nx[CW-1], nx}) - $signed({old_x[CW-1], old_x});
  assign diff_y = $signed({ny[CW-1], ny}) - $signed({old_y[CW-1], old_y});
  assign sq_sum = {1'b0, sqx} + {1'b0, sqy};

  always_comb begin
    case (state)
      S_SQX:   mul_op = dx[15:0];
      S_SQY:   mul_op = dy[15:0];
      default: mul_op = move_tolerance;
    endcase
  end
  assign prod = mul_op * mul_op;

  always_comb begin
    ram_we   = 1'b0;
    ram_addr = cmd_addr;
    ram_wx   = cmd_x;
    ram_wy   = cmd_y;
    case (state)
      S_WRITE: begin
        ram_we = cmd_inside;
      end
      S_NODE: begin
        case (ph)
          3'd0:    ram_addr = {row, col - CB'(1)};
          3'd1:    ram_addr = {row, col + CB'(1)};
          3'd2:    ram_addr = {row - RB'(1), col};
          3'd3:    ram_addr = {row + RB'(1), col};
          default: ram_addr = {row, col};
        endcase
      end
      S_UPD: begin
        ram_we   = 1'b1;
        ram_addr = {row, col};
        ram_wx   = nx;
        ram_wy   = ny;
      end
      default: ;
    endcase
  end

  gls_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_x_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wx), .rdata(ram_rx)
  );
  gls_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_y_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wy), .rdata(ram_ry)
  );

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_columns    <= COLUMNS_RESET;
      grid_rows       <= ROWS_RESET;
      move_tolerance  <= '0;
      iteration_limit <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_COLUMNS: grid_columns    <= cfg_data[6:0];
        REG_ROWS:    grid_rows       <= cfg_data[6:0];
        REG_TOL:     move_tolerance  <= cfg_data;
        REG_LIMIT:   iteration_limit <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // command latch and datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_inside <= ({3'b0, row_index} < 9'(MAX_ROWS)) &&
                    ({3'b0, column_index} < 9'(MAX_COLUMNS));
      cmd_addr   <= {RB'(row_index), CB'(column_index)};
      cmd_x      <= wx_ext[CW-1:0];
      cmd_y      <= wy_ext[CW-1:0];
    end
    if (state == S_NODE) begin
      case (ph)
        3'd1: begin
          sum_x <= SW'($signed(ram_rx));
          sum_y <= SW'($signed(ram_ry));
        end
        3'd2, 3'd3, 3'd4: begin
          sum_x <= sum_x + SW'($signed(ram_rx));
          sum_y <= sum_y + SW'($signed(ram_ry));
        end
        3'd5: begin
          old_x <= ram_rx;
          old_y <= ram_ry;
        end
        default: ;
      endcase
    end
    if (state == S_UPD) begin
      dx <= diff_x[DW-1] ? DW'(-diff_x) : DW'(diff_x);
      dy <= diff_y[DW-1] ? DW'(-diff_y) : DW'(diff_y);
    end
    if (state == S_TOL) begin
      tol2     <= prod;
      col_last <= CB'(cols_eff - 9'd2);
      row_last <= RB'(rows_eff - 9'd2);
    end
    if (state == S_SQX) begin
      sqx <= prod;
    end
    if (state == S_SQY) begin
      sqy <= prod;
    end
    if (state == S_READ_OUT) begin
      out_x <= cmd_inside ? rx_ext[31:0] : '0;
      out_y <= cmd_inside ? ry_ext[31:0] : '0;
    end else if (state == S_WRITE || state == S_TOL || state == S_SWEEP ||
                 state == S_NEXT || (state == S_IDLE && accept)) begin
      out_x <= '0;
      out_y <= '0;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      done           <= 1'b0;
      last_sweeps    <= '0;
      last_converged <= 1'b0;
      ph             <= '0;
      row            <= '0;
      col            <= '0;
      sweeps         <= '0;
      moved          <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (func)
              FUNC_WRITE: state <= S_WRITE;
              FUNC_RUN:   state <= S_TOL;
              FUNC_READ:  state <= S_READ;
              default: begin
                done <= 1'b1;  // unused code: status only
              end
            endcase
          end
        end
        S_WRITE: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        S_READ: begin
          state <= S_READ_OUT;
        end
        S_READ_OUT: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        S_TOL: begin
          sweeps <= '0;
          if (iteration_limit == '0) begin
            last_sweeps    <= '0;
            last_converged <= 1'b0;
            done           <= 1'b1;
            state          <= S_IDLE;
          end else begin
            state <= S_SWEEP;
          end
        end
        S_SWEEP: begin
          if (cols_eff < 9'd3 || rows_eff < 9'd3) begin
            // no interior: one empty sweep, converged
            last_sweeps    <= 10'd1;
            last_converged <= 1'b1;
            done           <= 1'b1;
            state          <= S_IDLE;
          end else begin
            row   <= RB'(1);
            col   <= CB'(1);
            moved <= 1'b0;
            ph    <= '0;
            state <= S_NODE;
          end
        end
        S_NODE: begin
          if (ph == 3'd5) begin
            ph    <= '0;
            state <= S_UPD;
          end else begin
            ph <= ph + 3'd1;
          end
        end
        S_UPD: begin
          state <= S_CHK;
        end
        S_CHK: begin
          if (dx > DW'(move_tolerance) || dy > DW'(move_tolerance)) begin
            moved <= 1'b1;
            state <= S_NEXT;
          end else begin
            state <= S_SQX;
          end
        end
        S_SQX: begin
          state <= S_SQY;
        end
        S_SQY: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (sq_sum > {1'b0, tol2}) begin
            moved <= 1'b1;
          end
          state <= S_NEXT;
        end
        S_NEXT: begin
          if (col == col_last) begin
            col <= CB'(1);
            if (row == row_last) begin
              sweeps <= sweeps + 10'd1;
              if (!moved) begin
                last_sweeps    <= sweeps + 10'd1;
                last_converged <= 1'b1;
                done           <= 1'b1;
                state          <= S_IDLE;
              end else if (sweeps + 10'd1 == iteration_limit) begin
                last_sweeps    <= sweeps + 10'd1;
                last_converged <= 1'b0;
                done           <= 1'b1;
                state          <= S_IDLE;
              end else begin
                state <= S_SWEEP;
              end
            end else begin
              row   <= row + RB'(1);
              state <= S_NODE;
            end
          end else begin
            col   <= col + CB'(1);
            state <= S_NODE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `GLS_ASSERT(a_done_idle, clk, rst, done |-> !busy, "result while busy")
  `GLS_ASSERT(a_accept_busy, clk, rst, (start && !busy && func != FUNC_UNUSED) |=> busy,
              "command not taken")
  `GLS_ASSERT_ALWAYS(a_conv_sweeps, clk, converged |-> (sweeps_done != 10'd0),
                     "converged with no sweep")
  `GLS_ASSERT(a_sq_in_tol, clk, rst,
              (state == S_SQX) |-> (dx <= DW'(move_tolerance) && dy <= DW'(move_tolerance)),
              "square check outside tolerance")

endmodule
